FILE: rtl/pgma_pkg.sv
// Shared types and constants for the pixel gradient magnitude / angle block.
// No dependencies; used by every module of the block.
package pgma_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STEPS   = 14;
	localparam int QDEPTH       = 4;

	// 180 degrees in 1/16 degree, and the same scaled by 2^16
	localparam logic signed [12:0] HALF_TURN_16 = 13'sd2880;
	localparam logic signed [30:0] HALF_TURN_Z  = 31'sd188743680;

	// atan(2^-i) in units of 2^-16 of 1/16 degree
	localparam logic [26:0] ARC_TABLE [CORDIC_STEPS] = '{
		27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
		27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
		27'd234682,   27'd117342,   27'd58671,    27'd29335,
		27'd14668,    27'd7334,     27'd3667,     27'd1833
	};

	// one classified item: central differences plus position
	typedef struct packed {
		logic signed [8:0] gx;
		logic signed [8:0] gy;
		logic [11:0]       row;
		logic [9:0]        column;
		logic              last;
	} grad_t;

endpackage

FILE: rtl/pixel_gradient_magnitude_angle.sv
// Top level of the gradient magnitude / orientation block.
// Depends on pgma_pkg, pgma_front, pgma_queue and pgma_back.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid/s_tready      s_tdata: pixel
//  m_*      out  m_tvalid/m_tready      m_tdata: row, column, magnitude, angle; m_tlast
//  cfg_*    in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// The line stores are read in the read phase and written on the pixel beat
// in the take phase that follows, over a single port each; pixels are taken only then.
// The back end is a 17-stage pipeline plus an output register.
// Reset clears counters and taps; line stores are not cleared.
// Output stalls freeze the back pipeline; the 4-entry queue absorbs the front.
module pixel_gradient_magnitude_angle #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [11:0] row, [21:12] column, [34:22] magnitude, [47:35] angle
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);
	logic            q_full, q_push, q_empty, q_pop;
	pgma_pkg::grad_t q_item, q_head;

	assign cfg_ready = 1'b1;

	pgma_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	pgma_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_item),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	pgma_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

FILE: rtl/pgma_front.sv
// Front end: pixel intake, line stores, taps, raster counters, register file.
// Produces pgma_pkg::grad_t items for every interior pixel. Depends on pgma_pkg.
module pgma_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               cfg_valid,
	input  logic               cfg_index,
	input  logic [12:0]        cfg_data,
	input  logic               q_full,
	output logic               q_push,
	output pgma_pkg::grad_t    q_item
);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int CCMP = ((CW > 11) ? CW : 11) + 1;
	localparam int RCMP = ((RW > 13) ? RW : 13) + 1;
	localparam logic PH_READ = 1'b0;
	localparam logic PH_TAKE = 1'b1;
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	logic [7:0] above_mem [MAX_WIDTH];
	logic [7:0] two_above_mem [MAX_WIDTH];

	logic            phase_q;
	logic [10:0]     frame_width_q;
	logic [12:0]     frame_height_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [7:0]      a1_q, a2_q;
	logic [7:0]      left0_q, above0_q, above1_q, two_above_q;

	logic            accept;
	logic [CCMP-1:0] col_next, col_m1;
	logic [RCMP-1:0] row_next, row_m1;
	logic [12:0]     w_ext;
	logic [16:0]     h_ext;

	assign s_tready = (phase_q == PH_TAKE) && !q_full;
	assign accept   = s_tvalid && s_tready;
	assign col_next = CCMP'(col_q) + CCMP'(1);
	assign row_next = RCMP'(row_q) + RCMP'(1);
	assign col_m1   = CCMP'(col_q) - CCMP'(1);
	assign row_m1   = RCMP'(row_q) - RCMP'(1);
	assign w_ext    = {2'b00, cfg_data[10:0]};
	assign h_ext    = {4'b0000, cfg_data};

	assign q_push = accept && (row_q >= RW'(2)) && (col_q >= CW'(2));
	always_comb begin
		q_item.gx     = $signed({1'b0, a1_q}) - $signed({1'b0, above1_q});
		q_item.gy     = $signed({1'b0, left0_q}) - $signed({1'b0, two_above_q});
		q_item.row    = row_m1[11:0];
		q_item.column = col_m1[9:0];
		q_item.last   = (row_next == RCMP'(frame_height_q)) &&
			(col_next == CCMP'(frame_width_q));
	end

	// line stores: read in the first phase, written at the pixel beat
	always_ff @(posedge clk) begin
		if (phase_q == PH_READ) begin
			a1_q <= above_mem[col_q];
			a2_q <= two_above_mem[col_q];
		end
		if (accept) begin
			two_above_mem[col_q] <= a1_q;
			above_mem[col_q]     <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_READ;
			frame_width_q  <= 11'd640;
			frame_height_q <= 13'd480;
			col_q          <= '0;
			row_q          <= '0;
			left0_q        <= '0;
			above0_q       <= '0;
			above1_q       <= '0;
			two_above_q    <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_WIDTH: begin
						if (w_ext < 13'd3)
							frame_width_q <= 11'd3;
						else if (w_ext > 13'(MAX_WIDTH))
							frame_width_q <= 11'(MAX_WIDTH);
						else
							frame_width_q <= cfg_data[10:0];
					end
					CFG_HEIGHT: begin
						if (h_ext < 17'd3)
							frame_height_q <= 13'd3;
						else if (h_ext > 17'(MAX_HEIGHT))
							frame_height_q <= 13'(MAX_HEIGHT);
						else
							frame_height_q <= cfg_data;
					end
					default: ;
				endcase
			end
			if (phase_q == PH_READ) begin
				phase_q <= PH_TAKE;
			end else if (accept) begin
				phase_q     <= PH_READ;
				above1_q    <= above0_q;
				above0_q    <= a1_q;
				left0_q     <= s_tdata;
				two_above_q <= a2_q;
				if (col_next >= CCMP'(frame_width_q)) begin
					col_q <= '0;
					if (row_next >= RCMP'(frame_height_q))
						row_q <= '0;
					else
						row_q <= row_next[RW-1:0];
				end else begin
					col_q <= col_next[CW-1:0];
				end
			end
		end
	end

endmodule

FILE: rtl/pgma_queue.sv
// Short FIFO between the front end and the arithmetic back end.
// Depends on pgma_pkg for the item type and depth.
module pgma_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pgma_pkg::grad_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output pgma_pkg::grad_t head
);
	localparam int AW = $clog2(pgma_pkg::QDEPTH);

	pgma_pkg::grad_t slots_q [pgma_pkg::QDEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     count_q;

	assign full  = count_q == (AW+1)'(pgma_pkg::QDEPTH);
	assign empty = count_q == '0;
	assign head  = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + AW'(1);
			if (pop)
				rd_q <= rd_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + (AW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (AW+1)'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(pgma_pkg::QDEPTH)) else $error("queue count out of range");

endmodule

FILE: rtl/pgma_back.sv
// Back end: pipelined integer square root and CORDIC vectoring, output register.
// Depends on pgma_pkg for the item type and the arctangent table.
module pgma_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  pgma_pkg::grad_t q_head,
	output logic            q_pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [47:0]     m_tdata,
	output logic            m_tlast
);
	localparam int NS = pgma_pkg::CORDIC_STEPS;

	logic                en;
	logic [NS:0]         vld_q;
	logic signed [26:0]  x_q [NS+1];
	logic signed [26:0]  y_q [NS+1];
	logic signed [30:0]  z_q [NS+1];
	logic [27:0]         v_q [NS+1];
	logic [15:0]         rem_q [NS+1];
	logic [13:0]         root_q [NS+1];
	logic [NS:0]         zero_q;
	pgma_pkg::grad_t     pos_q [NS+1];

	logic signed [8:0]   gx_a, gy_a;
	logic                neg;
	logic [16:0]         sq;
	logic signed [30:0]  z_round;
	logic signed [30:0]  z_sh;
	logic [14:0]         root_inc;

	assign en    = !m_tvalid || m_tready;
	assign q_pop = en && !q_empty;

	// stage 0: fold the left half plane, square sum for the root
	always_comb begin
		neg  = q_head.gx < 0;
		gx_a = neg ? -q_head.gx : q_head.gx;
		gy_a = neg ? -q_head.gy : q_head.gy;
		sq   = 17'(18'(q_head.gx) * 18'(q_head.gx)) +
			17'(18'(q_head.gy) * 18'(q_head.gy));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]    <= {{2{gx_a[8]}}, gx_a, 16'h0000};
			y_q[0]    <= {{2{gy_a[8]}}, gy_a, 16'h0000};
			if (!neg)
				z_q[0] <= '0;
			else if (q_head.gy >= 0)
				z_q[0] <= pgma_pkg::HALF_TURN_Z;
			else
				z_q[0] <= -pgma_pkg::HALF_TURN_Z;
			v_q[0]    <= {1'b0, sq, 10'h000};
			rem_q[0]  <= '0;
			root_q[0] <= '0;
			zero_q[0] <= (q_head.gx == 0) && (q_head.gy == 0);
			pos_q[0]  <= q_head;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_step
		logic signed [26:0] xs, ys;
		logic signed [30:0] arc;
		logic [17:0]        t;
		logic [15:0]        trial;
		always_comb begin
			xs    = x_q[i] >>> i;
			ys    = y_q[i] >>> i;
			arc   = 31'(pgma_pkg::ARC_TABLE[i]);
			t     = {rem_q[i], v_q[i][27:26]};
			trial = {root_q[i], 2'b01};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] + ys;
					y_q[i+1] <= y_q[i] - xs;
					z_q[i+1] <= z_q[i] + arc;
				end else begin
					x_q[i+1] <= x_q[i] - ys;
					y_q[i+1] <= y_q[i] + xs;
					z_q[i+1] <= z_q[i] - arc;
				end
				if (i < pgma_pkg::SQRT_STEPS) begin
					v_q[i+1] <= {v_q[i][25:0], 2'b00};
					if (t >= {2'b00, trial}) begin
						rem_q[i+1]  <= 16'(t - {2'b00, trial});
						root_q[i+1] <= {root_q[i][12:0], 1'b1};
					end else begin
						rem_q[i+1]  <= t[15:0];
						root_q[i+1] <= {root_q[i][12:0], 1'b0};
					end
				end else begin
					v_q[i+1]    <= v_q[i];
					rem_q[i+1]  <= rem_q[i];
					root_q[i+1] <= root_q[i];
				end
				zero_q[i+1] <= zero_q[i];
				pos_q[i+1]  <= pos_q[i];
			end
		end
	end

	// output stage: round the angle half up, clamp, zero it for a zero gradient, halve the root
	always_comb begin
		z_round  = z_q[NS] + 31'sd32768;
		z_sh     = z_round >>> 16;
		root_inc = {1'b0, root_q[NS]} + 15'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata[11:0]  <= pos_q[NS].row;
			m_tdata[21:12] <= pos_q[NS].column;
			m_tdata[34:22] <= root_inc[13:1];
			if (zero_q[NS])
				m_tdata[47:35] <= '0;
			else if (z_sh > 31'(pgma_pkg::HALF_TURN_16))
				m_tdata[47:35] <= pgma_pkg::HALF_TURN_16;
			else if (z_sh < -31'(pgma_pkg::HALF_TURN_16))
				m_tdata[47:35] <= -pgma_pkg::HALF_TURN_16;
			else
				m_tdata[47:35] <= z_sh[12:0];
			m_tlast <= pos_q[NS].last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_q    <= {vld_q[NS-1:0], q_pop};
			m_tvalid <= vld_q[NS];
		end
	end

endmodule
